### sv/ctf_pkg.sv
// Shared constants and types for the complementary tilt filter.
`timescale 1ns / 1ps
package ctf_pkg;

    localparam int ATAN_LEN = 24;
    localparam int ATAN_IW  = $clog2(ATAN_LEN);

    localparam logic [21:0] ATAN_Q16 [ATAN_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
    };

    localparam logic [12:0] GYRO_RND    = 13'd8187;
    localparam logic [37:0] GYRO_RECIP  = 38'd137514492439;
    localparam int          RECIP_SHIFT = 51;
    localparam int          MUL_STEPS   = 4;
    localparam int          SQRT_STEPS  = 24;

    typedef enum logic [1:0] {
        REG_BIAS_X = 2'd0,
        REG_BIAS_Y = 2'd1,
        REG_BLEND  = 2'd2
    } t_reg_idx;

endpackage

### sv/imu_complementary_tilt_filter.sv
// Top level: roll/pitch complementary filter sequencer, blend and handshakes.
// From request to result: a start state, two square root passes with the gyro
// divisions alongside and the roll CORDIC under the second, the pitch CORDIC, four
// multiplier products and a final sum. One request at a time; the next is taken in
// the cycle after the result is registered, later while an earlier result stalls.
// Synchronous active-low reset clears the previous angles, the handshakes and the
// registers to defaults.
`timescale 1ns / 1ps
module imu_complementary_tilt_filter #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic [15:0]        i_elapsed_ms,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_roll_angle,
    output logic signed [23:0] o_pitch_angle
);
    import ctf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_GO   = 7'b0000010,
        S_WA   = 7'b0000100,
        S_WB   = 7'b0001000,
        S_WC   = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_SUM  = 7'b1000000
    } t_state;

    t_state             r_state;
    logic signed [15:0] r_bias_x, r_bias_y;
    logic [15:0]        r_blend;
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy;
    logic [15:0]        r_ms;
    logic signed [25:0] r_gp_x, r_gp_y;
    logic signed [17:0] r_acc_r, r_acc_p;
    logic signed [43:0] r_p [4];
    logic [1:0]         r_mk;
    logic signed [23:0] r_roll, r_pitch;
    logic               r_out_valid;

    logic               sq_start, sq_busy;
    logic signed [15:0] sq_a, sq_b;
    logic [23:0]        sq_root;
    logic               dv_start, dv_busy;
    logic signed [16:0] dv_diff;
    logic signed [24:0] dv_inc;
    logic               co_start, co_busy;
    logic signed [16:0] co_num;
    logic signed [17:0] co_angle;

    logic signed [17:0] n_wa;
    logic signed [25:0] n_mb;
    logic signed [43:0] n_prod;
    logic signed [44:0] n_sr, n_sp;
    logic signed [23:0] n_roll, n_pitch;

    function automatic logic signed [23:0] sat24(input logic signed [44:0] s);
        logic signed [28:0] sh;
        sh = s[44:16];
        if (sh > 29'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (sh < -29'sd8388608) begin
            return 24'sh800000;
        end
        return sh[23:0];
    endfunction

    always_comb begin
        sq_start = 1'b0;
        dv_start = 1'b0;
        co_start = 1'b0;
        sq_a     = r_ax;
        sq_b     = r_az;
        dv_diff  = 17'(r_gx) - 17'(r_bias_x);
        co_num   = 17'(r_ay);
        case (r_state)
            S_GO: begin
                sq_start = 1'b1;
                dv_start = 1'b1;
            end
            S_WA: begin
                sq_a    = r_ay;
                dv_diff = 17'(r_gy) - 17'(r_bias_y);
                if (!sq_busy && !dv_busy) begin
                    sq_start = 1'b1;
                    dv_start = 1'b1;
                    co_start = 1'b1;
                end
            end
            S_WB: begin
                co_num = -17'(r_ax);
                if (!sq_busy && !dv_busy && !co_busy) begin
                    co_start = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (r_mk)
            2'd0: begin
                n_wa = $signed({2'b00, r_blend});
                n_mb = r_gp_x;
            end
            2'd1: begin
                n_wa = $signed({1'b0, 17'(17'h10000 - {1'b0, r_blend})});
                n_mb = 26'(r_acc_r);
            end
            2'd2: begin
                n_wa = $signed({2'b00, r_blend});
                n_mb = r_gp_y;
            end
            default: begin
                n_wa = $signed({1'b0, 17'(17'h10000 - {1'b0, r_blend})});
                n_mb = 26'(r_acc_p);
            end
        endcase
        n_prod  = 44'(n_wa) * 44'(n_mb);
        n_sr    = 45'(r_p[0]) + 45'(r_p[1]) + 45'sd32768;
        n_sp    = 45'(r_p[2]) + 45'(r_p[3]) + 45'sd32768;
        n_roll  = sat24(n_sr);
        n_pitch = sat24(n_sp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bias_x    <= '0;
            r_bias_y    <= '0;
            r_blend     <= 16'd62259;
            r_roll      <= '0;
            r_pitch     <= '0;
            r_out_valid <= 1'b0;
            r_mk        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BIAS_X: r_bias_x <= i_cfg_data;
                    REG_BIAS_Y: r_bias_y <= i_cfg_data;
                    REG_BLEND:  r_blend  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && i_out_ready && r_state != S_SUM) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ax    <= i_accel_x;
                        r_ay    <= i_accel_y;
                        r_az    <= i_accel_z;
                        r_gx    <= i_gyro_x;
                        r_gy    <= i_gyro_y;
                        r_ms    <= i_elapsed_ms;
                        r_state <= S_GO;
                    end
                end
                S_GO: r_state <= S_WA;
                S_WA: begin
                    if (!sq_busy && !dv_busy) begin
                        r_gp_x  <= 26'(r_roll) + 26'(dv_inc);
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (!sq_busy && !dv_busy && !co_busy) begin
                        r_acc_r <= co_angle;
                        r_gp_y  <= 26'(r_pitch) + 26'(dv_inc);
                        r_state <= S_WC;
                    end
                end
                S_WC: begin
                    if (!co_busy) begin
                        r_acc_p <= co_angle;
                        r_mk    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p[r_mk] <= n_prod;
                    r_mk      <= r_mk + 2'd1;
                    if (r_mk == 2'd3) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_roll      <= n_roll;
                        r_pitch     <= n_pitch;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    ctf_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_a     (sq_a),
        .i_b     (sq_b),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    ctf_gdiv u_gdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_diff  (dv_diff),
        .i_ms    (r_ms),
        .o_busy  (dv_busy),
        .o_inc   (dv_inc)
    );

    ctf_cordic #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (co_start),
        .i_num   (co_num),
        .i_root  (sq_root),
        .o_busy  (co_busy),
        .o_angle (co_angle)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch;

endmodule

### sv/ctf_isqrt.sv
// Iterative floor square root of (a^2 + b^2) * 65536, one result bit per cycle.
`timescale 1ns / 1ps
module ctf_isqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_a,
    input  logic signed [15:0] i_b,
    output logic               o_busy,
    output logic [23:0]        o_root
);
    import ctf_pkg::*;

    logic               r_busy;
    logic               r_load;
    logic [4:0]         r_k;
    logic signed [31:0] r_sa, r_sb;
    logic [47:0]        r_rad;
    logic [25:0]        r_rem;
    logic [23:0]        r_root;
    logic [27:0]        n_trial;
    logic [27:0]        n_t;
    logic [31:0]        n_ss;

    always_comb begin
        n_ss    = 32'(r_sa) + 32'(r_sb);
        n_trial = {r_rem, r_rad[47:46]};
        n_t     = {2'b00, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_load <= 1'b0;
            r_k    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_load <= 1'b1;
            r_sa   <= 32'(i_a) * 32'(i_a);
            r_sb   <= 32'(i_b) * 32'(i_b);
        end else if (r_load) begin
            r_load <= 1'b0;
            r_rad  <= {n_ss, 16'h0000};
            r_rem  <= '0;
            r_root <= '0;
            r_k    <= '0;
        end else if (r_busy) begin
            if (n_trial >= n_t) begin
                r_rem  <= 26'(n_trial - n_t);
                r_root <= {r_root[22:0], 1'b1};
            end else begin
                r_rem  <= n_trial[25:0];
                r_root <= {r_root[22:0], 1'b0};
            end
            r_rad <= {r_rad[45:0], 2'b00};
            r_k   <= r_k + 5'd1;
            if (r_k == 5'(SQRT_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

### sv/ctf_gdiv.sv
// Gyro increment: |d| * ms * 256 / 131000 rounded, by reciprocal multiplication.
`timescale 1ns / 1ps
module ctf_gdiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_diff,
    input  logic [15:0]        i_ms,
    output logic               o_busy,
    output logic signed [24:0] o_inc
);
    import ctf_pkg::*;

    logic        r_busy;
    logic        r_load;
    logic        r_neg;
    logic [1:0]  r_k;
    logic [31:0] r_mag;
    logic [36:0] r_num;
    logic [74:0] r_acc;
    logic [15:0] n_abs;
    logic [18:0] n_ma;
    logic [18:0] n_mb;
    logic [37:0] n_pp;
    logic [74:0] n_sh;
    logic [23:0] n_q;

    always_comb begin
        n_abs = i_diff[16] ? 16'(-i_diff) : i_diff[15:0];
        n_ma  = r_k[1] ? {1'b0, r_num[36:19]} : r_num[18:0];
        n_mb  = r_k[0] ? GYRO_RECIP[37:19] : GYRO_RECIP[18:0];
        n_pp  = 38'(n_ma) * 38'(n_mb);
        case (r_k)
            2'd0: n_sh = 75'(n_pp);
            2'd1: n_sh = 75'(n_pp) << 19;
            2'd2: n_sh = 75'(n_pp) << 19;
            default: n_sh = 75'(n_pp) << 38;
        endcase
        n_q = r_acc[RECIP_SHIFT +: 24];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_load <= 1'b0;
            r_k    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_load <= 1'b1;
            r_neg  <= i_diff[16];
            r_mag  <= 32'(n_abs) * 32'(i_ms);
        end else if (r_load) begin
            r_load <= 1'b0;
            r_num  <= {r_mag, 5'b00000} + 37'(GYRO_RND);
            r_acc  <= '0;
            r_k    <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + n_sh;
            r_k   <= r_k + 2'd1;
            if (r_k == 2'(MUL_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_inc  = r_neg ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});

endmodule

### sv/ctf_cordic.sv
// Vectoring CORDIC: atan2 of numerator over root in Q8 degrees, one step per cycle.
`timescale 1ns / 1ps
module ctf_cordic #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_num,
    input  logic [23:0]        i_root,
    output logic               o_busy,
    output logic signed [17:0] o_angle
);
    import ctf_pkg::*;

    logic               r_busy;
    logic [ATAN_IW-1:0] r_i;
    logic signed [27:0] r_x, r_y;
    logic signed [25:0] r_z;
    logic signed [17:0] r_angle;
    logic signed [27:0] n_dx, n_dy;
    logic signed [25:0] n_z;
    logic signed [25:0] n_zr;

    always_comb begin
        n_dx = r_y >>> r_i;
        n_dy = r_x >>> r_i;
        if (!r_y[27]) begin
            n_z = r_z + $signed({4'b0000, ATAN_Q16[r_i]});
        end else begin
            n_z = r_z - $signed({4'b0000, ATAN_Q16[r_i]});
        end
        n_zr = n_z + 26'sd128;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            if (i_root == '0 && i_num == '0) begin
                r_angle <= '0;
            end else begin
                r_busy <= 1'b1;
                r_x    <= $signed({4'b0000, i_root});
                r_y    <= $signed({{3{i_num[16]}}, i_num, 8'h00});
                r_z    <= '0;
                r_i    <= '0;
            end
        end else if (r_busy) begin
            if (!r_y[27]) begin
                r_x <= r_x + n_dx;
                r_y <= r_y - n_dy;
            end else begin
                r_x <= r_x - n_dx;
                r_y <= r_y + n_dy;
            end
            r_z <= n_z;
            r_i <= r_i + 1'b1;
            if (r_i == ATAN_IW'(CORDIC_ITERATIONS - 1)) begin
                r_busy  <= 1'b0;
                r_angle <= n_zr[25:8];
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_angle = r_angle;

endmodule

### tb/sv/imu_complementary_tilt_filter_tb.sv
// Self-checking testbench for the complementary tilt filter, with a scoreboard class.
`timescale 1ns / 1ps
module imu_complementary_tilt_filter_tb;
    import ctf_pkg::*;

    localparam int         CORDIC_ITERATIONS = 16;
    localparam logic [1:0] REG_UNUSED        = 2'd3;
    localparam int         STALL_LIMIT       = 20000;
    localparam int         SETTLE_CYCLES     = 100;
    localparam int         RANDOM_PER_PHASE  = 235;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic [15:0]        ms;
    } t_imu_sample;

    typedef struct packed {
        logic signed [23:0] roll;
        logic signed [23:0] pitch;
    } t_tilt_pair;

    class tilt_scoreboard;
        t_tilt_pair  exp_angles[$];
        int          errors;
        longint      bias_x;
        longint      bias_y;
        longint      weight;
        longint      roll_q8;
        longint      pitch_q8;

        function new();
            errors   = 0;
            bias_x   = 0;
            bias_y   = 0;
            weight   = 62259;
            roll_q8  = 0;
            pitch_q8 = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            if (idx == REG_BIAS_X) begin
                bias_x = longint'($signed(data));
            end else if (idx == REG_BIAS_Y) begin
                bias_y = longint'($signed(data));
            end else if (idx == REG_BLEND) begin
                weight = longint'(data);
            end
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint tilt_q8(longint n, longint a, longint b);
            longint unsigned ss;
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            ss = longint'(a * a) + longint'(b * b);
            x  = longint'(root_floor(ss << 16));
            y  = n * 256;
            z  = 0;
            if (x == 0 && y == 0) return 0;
            for (int i = 0; i < CORDIC_ITERATIONS && i < ATAN_LEN; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(ATAN_Q16[i]);
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(ATAN_Q16[i]);
                end
            end
            return (z + 128) >>> 8;
        endfunction

        function longint gyro_step_q8(longint raw, longint bias, longint ms);
            longint d;
            longint q;
            d = raw - bias;
            q = ((d < 0 ? -d : d) * ms * 256 + 65500) / 131000;
            return d < 0 ? -q : q;
        endfunction

        function longint blend(longint gyro_path, longint accel);
            longint r;
            r = (weight * gyro_path + (65536 - weight) * accel + 32768) >>> 16;
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
            return r;
        endfunction

        function void note_sample(t_imu_sample s);
            longint ax;
            longint ay;
            longint az;
            t_tilt_pair p;
            ax = longint'(s.ax);
            ay = longint'(s.ay);
            az = longint'(s.az);
            roll_q8  = blend(roll_q8 + gyro_step_q8(longint'(s.gx), bias_x, longint'(s.ms)),
                             tilt_q8(ay, ax, az));
            pitch_q8 = blend(pitch_q8 + gyro_step_q8(longint'(s.gy), bias_y, longint'(s.ms)),
                             tilt_q8(-ax, ay, az));
            p.roll  = roll_q8[23:0];
            p.pitch = pitch_q8[23:0];
            exp_angles.push_back(p);
        endfunction

        task report(string what, logic [23:0] got, logic [23:0] want);
            $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
            errors++;
        endtask

        task check_angles(logic signed [23:0] roll, logic signed [23:0] pitch);
            t_tilt_pair p;
            if (exp_angles.size() == 0) begin
                report("unexpected result roll", roll, 24'd0);
            end else begin
                p = exp_angles.pop_front();
                if (roll !== p.roll) report("roll", roll, p.roll);
                if (pitch !== p.pitch) report("pitch", pitch, p.pitch);
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [15:0] i_accel_x = '0;
    logic signed [15:0] i_accel_y = '0;
    logic signed [15:0] i_accel_z = '0;
    logic signed [15:0] i_gyro_x = '0;
    logic signed [15:0] i_gyro_y = '0;
    logic [15:0]        i_elapsed_ms = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [23:0] o_roll_angle;
    logic signed [23:0] o_pitch_angle;

    tilt_scoreboard sb;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet     = 0;

    imu_complementary_tilt_filter #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_angles(o_roll_angle, o_pitch_angle);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("** imu_complementary_tilt_filter: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task send_sample(t_imu_sample s);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_accel_x    <= s.ax;
        i_accel_y    <= s.ay;
        i_accel_z    <= s.az;
        i_gyro_x     <= s.gx;
        i_gyro_y     <= s.gy;
        i_elapsed_ms <= s.ms;
        i_in_valid   <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_sample(s);
    endtask

    task drain();
        i_in_valid <= 1'b0;
        while (sb.exp_angles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function t_imu_sample random_sample();
        t_imu_sample s;
        s = t_imu_sample'({$urandom, $urandom, $urandom});
        case ($urandom_range(5))
            0: begin
                s.ax = $signed(16'($urandom_range(6))) - 16'sd3;
                s.ay = $signed(16'($urandom_range(6))) - 16'sd3;
                s.az = $signed(16'($urandom_range(6))) - 16'sd3;
            end
            1: s.ms = 16'($urandom_range(20));
            2: begin
                s.az = '0;
                if ($urandom_range(1)) s.ax = '0; else s.ay = '0;
            end
            default: ;
        endcase
        return s;
    endfunction

    t_imu_sample directed[$];
    t_imu_sample s;

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0});
        directed.push_back('{16'sd0, 16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'd10});
        directed.push_back('{16'sd0, -16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'd10});
        directed.push_back('{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1});
        directed.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                             16'hFFFF});
        directed.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                             16'hFFFF});
        directed.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd131, -16'sd131, 16'd1000});
        directed.push_back('{16'sd100, 16'sd0, -16'sd16384, 16'sd5, 16'sd5, 16'd0});
        foreach (directed[i]) send_sample(directed[i]);
        drain();

        // drive both angles into saturation, then hold the gyro inputs at their biases
        write_reg(REG_BIAS_X, 16'h8000);
        write_reg(REG_BIAS_Y, 16'h7FFF);
        write_reg(REG_BLEND, 16'hFFFF);
        for (int i = 0; i < 6; i++) begin
            send_sample('{16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'hFFFF});
        end
        for (int i = 0; i < 4; i++) begin
            send_sample('{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd32767, 16'hFFFF});
        end
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            case (p)
                0: write_reg(REG_BLEND, 16'd0);
                1: write_reg(REG_BLEND, 16'd62259);
                2: write_reg(REG_UNUSED, 16'($urandom));
                default: begin
                    write_reg(REG_BIAS_X, 16'($urandom));
                    write_reg(REG_BIAS_Y, 16'($urandom));
                    write_reg(REG_BLEND, 16'($urandom));
                end
            endcase
            if (p == 3) begin
                write_reg(REG_BIAS_X, 16'h0000);
                write_reg(REG_BIAS_Y, 16'hFFFF);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (p == 1 && i == RANDOM_PER_PHASE / 2) begin
                    i_in_valid <= 1'b0;
                    while (sb.exp_angles.size() != 0) @(posedge i_clk);
                end
                s = random_sample();
                send_sample(s);
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("** imu_complementary_tilt_filter: PASSED **");
        end else begin
            $display("** imu_complementary_tilt_filter: FAILED **");
        end
        $finish;
    end
endmodule
